### hdl/ttf_pkg.sv
// shared types, constants and the product schedule of the tangent frame unit
package ttf_pkg;

  localparam int POS_W      = 32;
  localparam int TEX_W      = 24;
  localparam int OUT_W      = 16;
  localparam int EDGE_W     = POS_W + 1;
  localparam int PROD_W     = 2 * EDGE_W;
  localparam int VEC_W      = PROD_W + 1;
  localparam int M_W        = 30;
  localparam int SQ_W       = 2 * M_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int MUL_STEPS  = 20;
  localparam int STEP_W     = 5;
  localparam int OUTPUT_FRAC_BITS_DEF = 14;

  // multiplier operand codes
  localparam logic [3:0] OP_E1X = 4'd0;
  localparam logic [3:0] OP_E1Y = 4'd1;
  localparam logic [3:0] OP_E1Z = 4'd2;
  localparam logic [3:0] OP_E2X = 4'd3;
  localparam logic [3:0] OP_E2Y = 4'd4;
  localparam logic [3:0] OP_E2Z = 4'd5;
  localparam logic [3:0] OP_S1  = 4'd6;
  localparam logic [3:0] OP_T1  = 4'd7;
  localparam logic [3:0] OP_S2  = 4'd8;
  localparam logic [3:0] OP_T2  = 4'd9;

  // vector groups
  localparam logic [1:0] GRP_NORMAL    = 2'd0;
  localparam logic [1:0] GRP_TANGENT   = 2'd1;
  localparam logic [1:0] GRP_BITANGENT = 2'd2;

  typedef struct packed {
    logic              hold1;
    logic              hold2;
    logic              diff;
    logic              mul_en;
    logic [STEP_W-1:0] mul_step;
    logic              nload;
    logic              nshift;
    logic              sq_en;
    logic [1:0]        idx;
    logic              sqrt_init;
    logic              sqrt_step;
    logic              div_init;
    logic              div_step;
    logic              div_store;
    logic [1:0]        grp;
    logic              clr_grp;
    logic              clr_uv;
    logic              set_ndeg;
    logic              set_uvdeg;
    logic              out_load;
  } ttf_cmd_t;

  typedef struct packed {
    logic det_zero;
    logic vec_zero;
    logic aligned;
  } ttf_status_t;

  // product schedule: even steps load a*b, odd steps store acc - a*b
  // destinations by step/2: det, normal xyz, tangent xyz, bitangent xyz
  function automatic logic [7:0] mul_pair(input logic [STEP_W-1:0] step);
    logic [7:0] r;
    r = {OP_E1X, OP_E1X};
    case (step)
      5'd0:  r = {OP_S1,  OP_T2};
      5'd1:  r = {OP_S2,  OP_T1};
      5'd2:  r = {OP_E1Y, OP_E2Z};
      5'd3:  r = {OP_E1Z, OP_E2Y};
      5'd4:  r = {OP_E1Z, OP_E2X};
      5'd5:  r = {OP_E1X, OP_E2Z};
      5'd6:  r = {OP_E1X, OP_E2Y};
      5'd7:  r = {OP_E1Y, OP_E2X};
      5'd8:  r = {OP_T2,  OP_E1X};
      5'd9:  r = {OP_T1,  OP_E2X};
      5'd10: r = {OP_T2,  OP_E1Y};
      5'd11: r = {OP_T1,  OP_E2Y};
      5'd12: r = {OP_T2,  OP_E1Z};
      5'd13: r = {OP_T1,  OP_E2Z};
      5'd14: r = {OP_S1,  OP_E2X};
      5'd15: r = {OP_S2,  OP_E1X};
      5'd16: r = {OP_S1,  OP_E2Y};
      5'd17: r = {OP_S2,  OP_E1Y};
      5'd18: r = {OP_S1,  OP_E2Z};
      5'd19: r = {OP_S2,  OP_E1Z};
      default: r = {OP_E1X, OP_E1X};
    endcase
    return r;
  endfunction

endpackage

### hdl/ttf_datapath.sv
// datapath: vertex store, shared multiplier, normalizer, sqrt and divider
module ttf_datapath #(
  parameter int OUTPUT_FRAC_BITS = ttf_pkg::OUTPUT_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ttf_pkg::ttf_cmd_t                  cmd,
  output ttf_pkg::ttf_status_t               status,
  input  logic signed [ttf_pkg::POS_W-1:0]   pos_x,
  input  logic signed [ttf_pkg::POS_W-1:0]   pos_y,
  input  logic signed [ttf_pkg::POS_W-1:0]   pos_z,
  input  logic signed [ttf_pkg::TEX_W-1:0]   tex_u,
  input  logic signed [ttf_pkg::TEX_W-1:0]   tex_v,
  output logic signed [ttf_pkg::OUT_W-1:0]   normal_x,
  output logic signed [ttf_pkg::OUT_W-1:0]   normal_y,
  output logic signed [ttf_pkg::OUT_W-1:0]   normal_z,
  output logic signed [ttf_pkg::OUT_W-1:0]   tangent_x,
  output logic signed [ttf_pkg::OUT_W-1:0]   tangent_y,
  output logic signed [ttf_pkg::OUT_W-1:0]   tangent_z,
  output logic signed [ttf_pkg::OUT_W-1:0]   bitangent_x,
  output logic signed [ttf_pkg::OUT_W-1:0]   bitangent_y,
  output logic signed [ttf_pkg::OUT_W-1:0]   bitangent_z,
  output logic                               normal_degenerate,
  output logic                               uv_degenerate
);

  localparam int EW  = ttf_pkg::EDGE_W;
  localparam int PW  = ttf_pkg::PROD_W;
  localparam int VW  = ttf_pkg::VEC_W;
  localparam int MW  = ttf_pkg::M_W;
  localparam int RW  = ttf_pkg::ROOT_W;
  localparam int SW  = ttf_pkg::SUM_W;
  localparam int OW  = ttf_pkg::OUT_W;
  localparam int TW  = ttf_pkg::TEX_W;
  localparam int F   = OUTPUT_FRAC_BITS;
  localparam int NW  = MW + F + 1;
  localparam int QW  = F + 1;

  // held vertices
  logic signed [ttf_pkg::POS_W-1:0] hp [6];
  logic signed [TW-1:0]             ht [4];

  // edges and uv deltas
  logic signed [EW-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [TW:0]   s1, t1, s2, t2;

  // multiplier pipeline
  logic [7:0]           pair;
  logic signed [EW-1:0] opa, opb;
  logic signed [PW-1:0] prod, acc;
  logic                 pval;
  logic [ttf_pkg::STEP_W-1:0] pstep;
  logic signed [VW-1:0] dres;

  // raw vectors
  logic signed [VW-1:0] vdet;
  logic signed [VW-1:0] vnrm [3];
  logic signed [VW-1:0] vtan [3];
  logic signed [VW-1:0] vbit [3];

  // normalizer
  logic signed [VW-1:0] vsel [3];
  logic [VW-1:0]        mag [3];
  logic                 neg [3];
  logic [VW-1:0]        or_mag;
  logic                 flip;
  logic [MW-1:0]        msel;
  logic [ttf_pkg::SQ_W-1:0] sqp;
  logic                 sqv;
  logic [SW-1:0]        sum;

  // square root
  logic [SW-1:0]        sreg;
  logic [RW+1:0]        srem;
  logic [RW-1:0]        root;
  logic [RW+3:0]        strial;

  // divider
  logic [NW-1:0]        num;
  logic [RW-1:0]        drem;
  logic [QW-1:0]        dlow;
  logic [RW:0]          dtrial;
  logic [QW+OW-1:0]     qext;
  logic [OW-1:0]        q16, qval;

  // results
  logic [OW-1:0] res_n [3];
  logic [OW-1:0] res_t [3];
  logic [OW-1:0] res_b [3];
  logic          ndeg, uvdeg;
  logic [OW-1:0] out_n [3];
  logic [OW-1:0] out_t [3];
  logic [OW-1:0] out_b [3];
  logic          out_ndeg, out_uvdeg;

  // vertex store and edge differences
  always_ff @(posedge clk) begin
    if (cmd.hold1) begin
      hp[0] <= pos_x; hp[1] <= pos_y; hp[2] <= pos_z;
      ht[0] <= tex_u; ht[1] <= tex_v;
    end
    if (cmd.hold2) begin
      hp[3] <= pos_x; hp[4] <= pos_y; hp[5] <= pos_z;
      ht[2] <= tex_u; ht[3] <= tex_v;
    end
    if (cmd.diff) begin
      e1x <= EW'(hp[3]) - EW'(hp[0]);
      e1y <= EW'(hp[4]) - EW'(hp[1]);
      e1z <= EW'(hp[5]) - EW'(hp[2]);
      e2x <= EW'(pos_x) - EW'(hp[0]);
      e2y <= EW'(pos_y) - EW'(hp[1]);
      e2z <= EW'(pos_z) - EW'(hp[2]);
      s1  <= (TW+1)'(ht[2]) - (TW+1)'(ht[0]);
      t1  <= (TW+1)'(ht[3]) - (TW+1)'(ht[1]);
      s2  <= (TW+1)'(tex_u) - (TW+1)'(ht[0]);
      t2  <= (TW+1)'(tex_v) - (TW+1)'(ht[1]);
    end
  end

  // operand selection from the product schedule
  assign pair = ttf_pkg::mul_pair(cmd.mul_step);

  always_comb begin
    unique case (pair[7:4])
      ttf_pkg::OP_E1X: opa = e1x;
      ttf_pkg::OP_E1Y: opa = e1y;
      ttf_pkg::OP_E1Z: opa = e1z;
      ttf_pkg::OP_E2X: opa = e2x;
      ttf_pkg::OP_E2Y: opa = e2y;
      ttf_pkg::OP_E2Z: opa = e2z;
      ttf_pkg::OP_S1:  opa = EW'(s1);
      ttf_pkg::OP_T1:  opa = EW'(t1);
      ttf_pkg::OP_S2:  opa = EW'(s2);
      ttf_pkg::OP_T2:  opa = EW'(t2);
      default:         opa = '0;
    endcase
    unique case (pair[3:0])
      ttf_pkg::OP_E1X: opb = e1x;
      ttf_pkg::OP_E1Y: opb = e1y;
      ttf_pkg::OP_E1Z: opb = e1z;
      ttf_pkg::OP_E2X: opb = e2x;
      ttf_pkg::OP_E2Y: opb = e2y;
      ttf_pkg::OP_E2Z: opb = e2z;
      ttf_pkg::OP_S1:  opb = EW'(s1);
      ttf_pkg::OP_T1:  opb = EW'(t1);
      ttf_pkg::OP_S2:  opb = EW'(s2);
      ttf_pkg::OP_T2:  opb = EW'(t2);
      default:         opb = '0;
    endcase
  end

  // registered product, then loaded into the accumulator or subtracted from it into a vector component
  always_ff @(posedge clk) begin
    if (rst) begin
      pval <= 1'b0;
    end else begin
      pval <= cmd.mul_en;
    end
    pstep <= cmd.mul_step;
    if (cmd.mul_en) begin
      prod <= opa * opb;
    end
  end

  assign dres = VW'(acc) - VW'(prod);

  always_ff @(posedge clk) begin
    if (pval) begin
      if (!pstep[0]) begin
        acc <= prod;
      end else begin
        case (pstep[ttf_pkg::STEP_W-1:1])
          4'd0: vdet    <= dres;
          4'd1: vnrm[0] <= dres;
          4'd2: vnrm[1] <= dres;
          4'd3: vnrm[2] <= dres;
          4'd4: vtan[0] <= dres;
          4'd5: vtan[1] <= dres;
          4'd6: vtan[2] <= dres;
          4'd7: vbit[0] <= dres;
          4'd8: vbit[1] <= dres;
          4'd9: vbit[2] <= dres;
          default: ;
        endcase
      end
    end
  end

  // group select for normalization
  always_comb begin
    unique case (cmd.grp)
      ttf_pkg::GRP_TANGENT:   vsel = vtan;
      ttf_pkg::GRP_BITANGENT: vsel = vbit;
      default:                vsel = vnrm;
    endcase
  end

  assign flip   = (cmd.grp != ttf_pkg::GRP_NORMAL) && vdet[VW-1];
  assign or_mag = mag[0] | mag[1] | mag[2];

  assign status.det_zero = (vdet == '0);
  assign status.vec_zero = (or_mag == '0);
  assign status.aligned  = or_mag[VW-1];

  assign msel = mag[cmd.idx][VW-1 -: MW];

  // magnitudes, left alignment and sum of squares
  always_ff @(posedge clk) begin
    if (rst) begin
      sqv <= 1'b0;
    end else begin
      sqv <= cmd.sq_en;
    end
    if (cmd.nload) begin
      for (int i = 0; i < 3; i++) begin
        neg[i] <= vsel[i][VW-1] ^ flip;
        mag[i] <= vsel[i][VW-1] ? VW'(-vsel[i]) : VW'(vsel[i]);
      end
      sum <= '0;
    end else begin
      if (cmd.nshift) begin
        for (int i = 0; i < 3; i++) begin
          if (or_mag[VW-1 -: 8] == '0) begin
            mag[i] <= mag[i] << 8;
          end else begin
            mag[i] <= mag[i] << 1;
          end
        end
      end
      if (sqv) begin
        sum <= sum + SW'(sqp);
      end
    end
    if (cmd.sq_en) begin
      sqp <= msel * msel;
    end
  end

  // restoring square root, one result bit per step
  assign strial = {srem, sreg[SW-1 -: 2]} - (RW+4)'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sreg <= sum;
      srem <= '0;
      root <= '0;
    end else if (cmd.sqrt_step) begin
      sreg <= sreg << 2;
      if (!strial[RW+3]) begin
        srem <= strial[RW+1:0];
        root <= {root[RW-2:0], 1'b1};
      end else begin
        srem <= (RW+2)'({srem, sreg[SW-1 -: 2]});
        root <= {root[RW-2:0], 1'b0};
      end
    end
  end

  // restoring divider: ((m << F) + root/2) / root
  assign num    = (NW'(msel) << F) + NW'(root >> 1);
  assign dtrial = {drem, dlow[QW-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      drem <= RW'(num[NW-1:QW]);
      dlow <= num[QW-1:0];
    end else if (cmd.div_step) begin
      if (dtrial >= {1'b0, root}) begin
        drem <= RW'(dtrial - {1'b0, root});
        dlow <= {dlow[QW-2:0], 1'b1};
      end else begin
        drem <= RW'(dtrial);
        dlow <= {dlow[QW-2:0], 1'b0};
      end
    end
  end

  assign qext = {{OW{1'b0}}, dlow};
  assign q16  = qext[OW-1:0];
  assign qval = neg[cmd.idx] ? OW'(-q16) : q16;

  // result registers and degenerate flags
  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      unique case (cmd.grp)
        ttf_pkg::GRP_TANGENT:   res_t[cmd.idx] <= qval;
        ttf_pkg::GRP_BITANGENT: res_b[cmd.idx] <= qval;
        default:                res_n[cmd.idx] <= qval;
      endcase
    end
    if (cmd.clr_grp) begin
      for (int i = 0; i < 3; i++) res_n[i] <= '0;
    end
    if (cmd.clr_uv) begin
      for (int i = 0; i < 3; i++) begin
        res_t[i] <= '0;
        res_b[i] <= '0;
      end
    end
    if (cmd.diff) begin
      ndeg  <= 1'b0;
      uvdeg <= 1'b0;
    end else begin
      if (cmd.set_ndeg)  ndeg  <= 1'b1;
      if (cmd.set_uvdeg) uvdeg <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_n     <= res_n;
      out_t     <= res_t;
      out_b     <= res_b;
      out_ndeg  <= ndeg;
      out_uvdeg <= uvdeg;
    end
  end

  assign normal_x          = out_n[0];
  assign normal_y          = out_n[1];
  assign normal_z          = out_n[2];
  assign tangent_x         = out_t[0];
  assign tangent_y         = out_t[1];
  assign tangent_z         = out_t[2];
  assign bitangent_x       = out_b[0];
  assign bitangent_y       = out_b[1];
  assign bitangent_z       = out_b[2];
  assign normal_degenerate = out_ndeg;
  assign uv_degenerate     = out_uvdeg;

endmodule

### hdl/ttf_control.sv
// controller: vertex sequencing and the per-triangle command schedule
module ttf_control #(
  parameter int OUTPUT_FRAC_BITS = ttf_pkg::OUTPUT_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  ttf_pkg::ttf_status_t  status,
  output ttf_pkg::ttf_cmd_t     cmd
);

  localparam int MAXC  = (OUTPUT_FRAC_BITS > ttf_pkg::SQRT_STEPS) ?
                         OUTPUT_FRAC_BITS : ttf_pkg::SQRT_STEPS;
  localparam int CNT_W = $clog2(MAXC + 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MUL    = 4'd1;
  localparam logic [3:0] ST_NLOAD  = 4'd2;
  localparam logic [3:0] ST_ALIGN  = 4'd3;
  localparam logic [3:0] ST_UVCHK  = 4'd4;
  localparam logic [3:0] ST_SQ     = 4'd5;
  localparam logic [3:0] ST_SQI    = 4'd6;
  localparam logic [3:0] ST_SQRT   = 4'd7;
  localparam logic [3:0] ST_DIVI   = 4'd8;
  localparam logic [3:0] ST_DIV    = 4'd9;
  localparam logic [3:0] ST_DSTORE = 4'd10;
  localparam logic [3:0] ST_DONE   = 4'd11;

  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [1:0]       grp, grp_next;
  logic [1:0]       idx, idx_next;
  logic [1:0]       vcnt, vcnt_next;
  logic             out_valid_next;
  logic             in_acc;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    grp_next       = grp;
    idx_next       = idx;
    vcnt_next      = vcnt;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.grp        = grp;
    cmd.idx        = idx;
    cmd.mul_step   = cnt[ttf_pkg::STEP_W-1:0];

    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (vcnt == 2'd2) begin
            cmd.diff   = 1'b1;
            vcnt_next  = 2'd0;
            cnt_next   = '0;
            state_next = ST_MUL;
          end else if (vcnt == 2'd1) begin
            cmd.hold2 = 1'b1;
            vcnt_next = 2'd2;
          end else begin
            cmd.hold1 = 1'b1;
            vcnt_next = 2'd1;
          end
        end
      end
      ST_MUL: begin
        cmd.mul_en = (cnt < CNT_W'(ttf_pkg::MUL_STEPS));
        cnt_next   = cnt + 1'b1;
        if (cnt == CNT_W'(ttf_pkg::MUL_STEPS)) begin
          grp_next   = ttf_pkg::GRP_NORMAL;
          state_next = ST_NLOAD;
        end
      end
      ST_NLOAD: begin
        cmd.nload  = 1'b1;
        state_next = ST_ALIGN;
      end
      ST_ALIGN: begin
        priority if (status.vec_zero) begin
          if (grp == ttf_pkg::GRP_NORMAL) begin
            cmd.clr_grp  = 1'b1;
            cmd.set_ndeg = 1'b1;
            state_next   = ST_UVCHK;
          end else begin
            cmd.clr_uv    = 1'b1;
            cmd.set_uvdeg = 1'b1;
            state_next    = ST_DONE;
          end
        end else if (status.aligned) begin
          cnt_next   = '0;
          state_next = ST_SQ;
        end else begin
          cmd.nshift = 1'b1;
        end
      end
      ST_UVCHK: begin
        if (status.det_zero) begin
          cmd.clr_uv    = 1'b1;
          cmd.set_uvdeg = 1'b1;
          state_next    = ST_DONE;
        end else begin
          grp_next   = ttf_pkg::GRP_TANGENT;
          state_next = ST_NLOAD;
        end
      end
      ST_SQ: begin
        cmd.sq_en = (cnt < CNT_W'(3));
        cmd.idx   = cnt[1:0];
        cnt_next  = cnt + 1'b1;
        if (cnt == CNT_W'(3)) begin
          state_next = ST_SQI;
        end
      end
      ST_SQI: begin
        cmd.sqrt_init = 1'b1;
        cnt_next      = '0;
        idx_next      = 2'd0;
        state_next    = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == CNT_W'(ttf_pkg::SQRT_STEPS - 1)) begin
          state_next = ST_DIVI;
        end
      end
      ST_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(OUTPUT_FRAC_BITS)) begin
          state_next = ST_DSTORE;
        end
      end
      ST_DSTORE: begin
        cmd.div_store = 1'b1;
        if (idx == 2'd2) begin
          priority if (grp == ttf_pkg::GRP_NORMAL) begin
            state_next = ST_UVCHK;
          end else if (grp == ttf_pkg::GRP_TANGENT) begin
            grp_next   = ttf_pkg::GRP_BITANGENT;
            state_next = ST_NLOAD;
          end else begin
            state_next = ST_DONE;
          end
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_DIVI;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      grp       <= ttf_pkg::GRP_NORMAL;
      idx       <= 2'd0;
      vcnt      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      grp       <= grp_next;
      idx       <= idx_next;
      vcnt      <= vcnt_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef ASSERT_OFF
  // the vertex counter never reaches the unused code
  a_vcnt_range: assert property (@(posedge clk) disable iff (rst)
    vcnt != 2'd3) else $error("vertex count out of range");

  // squares only start on a left-aligned, nonzero vector
  a_sq_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQ) |-> (status.aligned && !status.vec_zero))
    else $error("sum of squares on unaligned vector");

  // only one datapath unit is stepped at a time
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.mul_en, cmd.nshift, cmd.sq_en, cmd.sqrt_step, cmd.div_step}))
    else $error("two datapath units stepped together");

  // a taken result drops valid unless a new one loads
  a_out_drop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !cmd.out_load) |=> !out_valid)
    else $error("result request repeated");
`endif

endmodule

### hdl/triangle_tangent_frame_unit.sv
// Triangle tangent frame unit: three vertex requests in, one frame request out.
// Each vertex is one input request; the first two are stored, and the third starts
// the frame computation. The square root and divider are bit-serial and shared by
// the three vectors; a degenerate vector skips them. The output is Q2.14 at the
// default OUTPUT_FRAC_BITS. No new vertex is taken while a triangle is in work,
// but a finished result waits in an output register while the vertices of the
// next triangle are accepted and its frame is computed.
module triangle_tangent_frame_unit #(
  parameter int OUTPUT_FRAC_BITS = ttf_pkg::OUTPUT_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [ttf_pkg::POS_W-1:0]  pos_x,
  input  logic signed [ttf_pkg::POS_W-1:0]  pos_y,
  input  logic signed [ttf_pkg::POS_W-1:0]  pos_z,
  input  logic signed [ttf_pkg::TEX_W-1:0]  tex_u,
  input  logic signed [ttf_pkg::TEX_W-1:0]  tex_v,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ttf_pkg::OUT_W-1:0]  normal_x,
  output logic signed [ttf_pkg::OUT_W-1:0]  normal_y,
  output logic signed [ttf_pkg::OUT_W-1:0]  normal_z,
  output logic signed [ttf_pkg::OUT_W-1:0]  tangent_x,
  output logic signed [ttf_pkg::OUT_W-1:0]  tangent_y,
  output logic signed [ttf_pkg::OUT_W-1:0]  tangent_z,
  output logic signed [ttf_pkg::OUT_W-1:0]  bitangent_x,
  output logic signed [ttf_pkg::OUT_W-1:0]  bitangent_y,
  output logic signed [ttf_pkg::OUT_W-1:0]  bitangent_z,
  output logic                              normal_degenerate,
  output logic                              uv_degenerate
);

  ttf_pkg::ttf_cmd_t    cmd;
  ttf_pkg::ttf_status_t status;

  // sequencing
  ttf_control #(
    .OUTPUT_FRAC_BITS(OUTPUT_FRAC_BITS)
  ) u_control (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic
  ttf_datapath #(
    .OUTPUT_FRAC_BITS(OUTPUT_FRAC_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .pos_x             (pos_x),
    .pos_y             (pos_y),
    .pos_z             (pos_z),
    .tex_u             (tex_u),
    .tex_v             (tex_v),
    .normal_x          (normal_x),
    .normal_y          (normal_y),
    .normal_z          (normal_z),
    .tangent_x         (tangent_x),
    .tangent_y         (tangent_y),
    .tangent_z         (tangent_z),
    .bitangent_x       (bitangent_x),
    .bitangent_y       (bitangent_y),
    .bitangent_z       (bitangent_z),
    .normal_degenerate (normal_degenerate),
    .uv_degenerate     (uv_degenerate)
  );

endmodule

### bench/tb_top.sv
// self-checking testbench of the triangle tangent frame unit
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OFRAC = ttf_pkg::OUTPUT_FRAC_BITS_DEF;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [ttf_pkg::POS_W-1:0] px;
    logic signed [ttf_pkg::POS_W-1:0] py;
    logic signed [ttf_pkg::POS_W-1:0] pz;
    logic signed [ttf_pkg::TEX_W-1:0] u;
    logic signed [ttf_pkg::TEX_W-1:0] v;
  } vertex_t;

  typedef struct packed {
    logic [9*ttf_pkg::OUT_W-1:0] vecs;
    logic                        ndeg;
    logic                        uvdeg;
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [ttf_pkg::POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [ttf_pkg::TEX_W-1:0] tex_u = '0, tex_v = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [ttf_pkg::OUT_W-1:0] normal_x, normal_y, normal_z;
  logic signed [ttf_pkg::OUT_W-1:0] tangent_x, tangent_y, tangent_z;
  logic signed [ttf_pkg::OUT_W-1:0] bitangent_x, bitangent_y, bitangent_z;
  logic normal_degenerate, uv_degenerate;

  vertex_t pending_vertices[$];
  frame_t  expected_frames[$];
  int      total_vertices;
  int      sent_vertices = 0;
  int      error_count = 0;
  int      stall_cycles = 0;
  logic    in_fire = 1'b0;

  // stored corners of the triangle under assembly
  vertex_t corner1, corner2;
  int      corner_count = 0;

  string field_names[9] = '{"normal_x", "normal_y", "normal_z", "tangent_x", "tangent_y",
                            "tangent_z", "bitangent_x", "bitangent_y", "bitangent_z"};

  triangle_tangent_frame_unit u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic logic [63:0] int_sqrt(input logic [63:0] s);
    logic [63:0] res, b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // scale to a 30-bit peak, then divide by the integer root of the square sum
  function automatic logic to_unit(input logic signed [127:0] a, input logic signed [127:0] b,
                                   input logic signed [127:0] c, input logic flip,
                                   output logic [3*ttf_pkg::OUT_W-1:0] o);
    logic signed [127:0] comp[3];
    logic [127:0] mag[3], orall, sh;
    logic neg[3];
    logic [63:0] m[3], s, r, q;
    int top;
    comp[0] = a; comp[1] = b; comp[2] = c;
    orall = 0; s = 0; top = -1; o = '0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = comp[i] < 0;
      mag[i] = neg[i] ? -comp[i] : comp[i];
      neg[i] = neg[i] ^ flip;
      orall |= mag[i];
    end
    for (int i = 127; i >= 0; i--)
      if (top < 0 && orall[i]) top = i;
    if (top < 0) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      sh = (top > 29) ? (mag[i] >> (top - 29)) : (mag[i] << (29 - top));
      m[i] = sh[63:0] & 64'h3FFF_FFFF;
      s += m[i] * m[i];
    end
    r = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << OFRAC) + (r >> 1)) / r;
      if (neg[i]) q = -q;
      o[(2-i)*ttf_pkg::OUT_W +: ttf_pkg::OUT_W] = q[ttf_pkg::OUT_W-1:0];
    end
    return 1'b1;
  endfunction

  // frame of the triangle closed by vertex c3
  function automatic frame_t triangle_frame(input vertex_t c1, input vertex_t c2,
                                            input vertex_t c3);
    logic signed [127:0] e1[3], e2[3], n[3], tg[3], bt[3];
    logic signed [127:0] s1, t1, s2, t2, det;
    logic [3*ttf_pkg::OUT_W-1:0] nv, tv, bv;
    logic nok, uvok;
    frame_t f;
    e1[0] = c2.px - c1.px; e1[1] = c2.py - c1.py; e1[2] = c2.pz - c1.pz;
    e2[0] = c3.px - c1.px; e2[1] = c3.py - c1.py; e2[2] = c3.pz - c1.pz;
    s1 = c2.u - c1.u; t1 = c2.v - c1.v;
    s2 = c3.u - c1.u; t2 = c3.v - c1.v;
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    nok = to_unit(n[0], n[1], n[2], 1'b0, nv);
    det = s1 * t2 - s2 * t1;
    for (int i = 0; i < 3; i++) begin
      tg[i] = t2 * e1[i] - t1 * e2[i];
      bt[i] = s1 * e2[i] - s2 * e1[i];
    end
    uvok = det != 0;
    if (uvok) uvok = to_unit(tg[0], tg[1], tg[2], det < 0, tv);
    if (uvok) uvok = to_unit(bt[0], bt[1], bt[2], det < 0, bv);
    if (!uvok) begin
      tv = '0;
      bv = '0;
    end
    f.vecs = {nv, tv, bv};
    f.ndeg = !nok;
    f.uvdeg = !uvok;
    return f;
  endfunction

  function automatic vertex_t mk(input int x, input int y, input int z, input int u,
                                 input int v);
    vertex_t w;
    w.px = x; w.py = y; w.pz = z; w.u = u; w.v = v;
    return w;
  endfunction

  function automatic int rnd_small(input int span);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  function automatic vertex_t rnd_vertex(input logic wide);
    vertex_t w;
    logic [31:0] r;
    if (wide) begin
      w.px = $urandom; w.py = $urandom; w.pz = $urandom;
      r = $urandom; w.u = r[23:0];
      r = $urandom; w.v = r[23:0];
    end else begin
      w = mk(rnd_small(1 << 20), rnd_small(1 << 20), rnd_small(1 << 20),
             rnd_small(1 << 18), rnd_small(1 << 18));
    end
    return w;
  endfunction

  task automatic add_triangle(input vertex_t a, input vertex_t b, input vertex_t c);
    pending_vertices.push_back(a);
    pending_vertices.push_back(b);
    pending_vertices.push_back(c);
  endtask

  function automatic int sender_idle_pct();
    int ph;
    ph = (sent_vertices * 3) / total_vertices;
    return ph == 0 ? 9 : (ph == 1 ? 53 : 0);
  endfunction

  function automatic int receiver_idle_pct();
    int ph;
    ph = (sent_vertices * 3) / total_vertices;
    return ph == 0 ? 53 : (ph == 1 ? 9 : 0);
  endfunction

  // vertex driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_vertices.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
        vertex_t w;
        w = pending_vertices.pop_front();
        sent_vertices++;
        pos_x <= w.px; pos_y <= w.py; pos_z <= w.pz;
        tex_u <= w.u; tex_v <= w.v;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= receiver_idle_pct());
  end

  // accepted vertex requests feed the frame predictor
  always @(posedge clk) begin
    in_fire <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      vertex_t w;
      w = mk(pos_x, pos_y, pos_z, tex_u, tex_v);
      if (corner_count == 0) begin
        corner1 = w;
        corner_count = 1;
      end else if (corner_count == 1) begin
        corner2 = w;
        corner_count = 2;
      end else begin
        expected_frames.push_back(triangle_frame(corner1, corner2, w));
        corner_count = 0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      frame_t want;
      logic [9*ttf_pkg::OUT_W-1:0] got;
      got = {normal_x, normal_y, normal_z, tangent_x, tangent_y, tangent_z,
             bitangent_x, bitangent_y, bitangent_z};
      if (expected_frames.size() == 0) begin
        report_mismatch("unexpected frame request", 32'd1, 32'd0);
      end else begin
        want = expected_frames.pop_front();
        for (int k = 0; k < 9; k++)
          if (got[(8-k)*ttf_pkg::OUT_W +: ttf_pkg::OUT_W] !==
              want.vecs[(8-k)*ttf_pkg::OUT_W +: ttf_pkg::OUT_W])
            report_mismatch(field_names[k], got[(8-k)*ttf_pkg::OUT_W +: ttf_pkg::OUT_W],
                            want.vecs[(8-k)*ttf_pkg::OUT_W +: ttf_pkg::OUT_W]);
        if (normal_degenerate !== want.ndeg)
          report_mismatch("normal_degenerate", normal_degenerate, want.ndeg);
        if (uv_degenerate !== want.uvdeg)
          report_mismatch("uv_degenerate", uv_degenerate, want.uvdeg);
      end
    end
  end

  // watchdog on cycles without any accepted request
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    vertex_t a, b;
    int mode;
    // directed triangles
    add_triangle(mk(0, 0, 0, 0, 0), mk(65536, 0, 0, 65536, 0), mk(0, 65536, 0, 0, 65536));
    // mirrored uv, negative determinant
    add_triangle(mk(0, 0, 0, 0, 0), mk(65536, 0, 0, 0, 65536), mk(0, 65536, 0, 65536, 0));
    // position and uv extremes
    add_triangle(mk(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 24'h80_0000, 24'h80_0000),
                 mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 24'h7F_FFFF, 24'h80_0000),
                 mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 24'h80_0000, 24'h7F_FFFF));
    add_triangle(mk(-1, -1, -1, -1, -1), mk(32'h7FFF_FFFF, 0, 0, 24'h7F_FFFF, 0),
                 mk(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 24'h7F_FFFF));
    // collinear corners, zero normal
    add_triangle(mk(0, 0, 0, 0, 0), mk(100, 200, 300, 65536, 0), mk(200, 400, 600, 0, 65536));
    // repeated uv, zero determinant
    add_triangle(mk(0, 0, 0, 5, 5), mk(65536, 0, 0, 5, 5), mk(0, 65536, 0, 5, 5));
    // all corners equal: zero normal and zero tangents with nonzero determinant
    add_triangle(mk(7, 7, 7, 0, 0), mk(7, 7, 7, 65536, 0), mk(7, 7, 7, 0, 65536));
    // tiny vectors that scale up
    add_triangle(mk(0, 0, 0, 0, 0), mk(1, 0, 0, 1, 0), mk(0, 1, 1, 0, 1));
    // random triangles
    for (int t = 0; t < 525; t++) begin
      mode = $urandom_range(19);
      a = rnd_vertex(mode < 3);
      b = rnd_vertex(mode < 3);
      if (mode == 3) add_triangle(a, b, a);
      else if (mode == 4) add_triangle(a, b, mk(rnd_small(99), 0, 9, a.u, a.v));
      else if (mode == 5) add_triangle(a, mk(b.px, b.py, b.pz, a.u, a.v),
                                       mk(a.px + 3, a.py, a.pz, a.u, a.v));
      else add_triangle(a, b, rnd_vertex(mode < 3));
    end
    total_vertices = pending_vertices.size();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (pending_vertices.size() == 0 && !in_valid);
    wait (expected_frames.size() == 0);
    repeat (400) @(posedge clk);
    if (expected_frames.size() != 0)
      report_mismatch("frames never delivered", expected_frames.size(), 0);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

### files.f
hdl/ttf_pkg.sv
hdl/ttf_datapath.sv
hdl/ttf_control.sv
hdl/triangle_tangent_frame_unit.sv
bench/tb_top.sv
